// File: sv/bws_pkg.sv
package bws_pkg;

   // Field widths fixed by the register map and the result format.
   localparam int WEIGHT_W   = 16;
   localparam int DIM_W      = 5;
   localparam int OUT_W      = 26;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Q15 prediction constants.
   localparam int Q_SHIFT    = 15;
   localparam int ROUND_HALF = 16384;

   // Register reset values and the largest value a dimension field holds.
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd16384;
   localparam logic [DIM_W-1:0]    DIM_RESET    = 5'd16;
   localparam int                  DIM_FIELD_MAX = 31;

   // Saturation value of the result field.
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_FIRST  = 3'd0,
      CSR_WEIGHT_SECOND = 3'd1,
      CSR_WIDTH         = 3'd2,
      CSR_HEIGHT        = 3'd3,
      CSR_AC_MODE       = 3'd4
   } csr_index_type;

   // Configuration seen by the controller and the datapath.
   typedef struct packed {
      logic [WEIGHT_W-1:0] weight_first;
      logic [WEIGHT_W-1:0] weight_second;
      logic                ac_mode;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic pred_en;
      logic sq_en;
      logic acc_en;
      logic mul_load;
      logic mul_step;
      logic div_load;
      logic div_step;
      logic finish;
      logic use_dc;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

// File: sv/bws_if.sv
// Pixel triple channel.
interface bws_req_if #(parameter int PIXEL_BITS = 8) ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] cur_pixel;
   logic [PIXEL_BITS-1:0] ref1_pixel;
   logic [PIXEL_BITS-1:0] ref2_pixel;

   modport source (output valid, output cur_pixel, output ref1_pixel, output ref2_pixel,
                   input ready);
   modport sink (input valid, input cur_pixel, input ref1_pixel, input ref2_pixel,
                 output ready);
endinterface

// Block energy channel.
interface bws_rsp_if ();
   logic                        valid;
   logic                        ready;
   logic [bws_pkg::OUT_W-1:0]   error_energy;

   modport source (output valid, output error_energy, input ready);
   modport sink (input valid, input error_energy, output ready);
endinterface

// File: sv/bws_csr.sv
module bws_csr #(
   parameter int MAX_BLOCK_DIM = 16,
   parameter int CNT_W         = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bws_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bws_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output bws_pkg::cfg_type                    cfg,
   output logic [CNT_W-1:0]                    total
);

   localparam int DIM_EFF = (MAX_BLOCK_DIM < bws_pkg::DIM_FIELD_MAX) ?
                            MAX_BLOCK_DIM : bws_pkg::DIM_FIELD_MAX;
   localparam int RESET_DIM = (int'(bws_pkg::DIM_RESET) < DIM_EFF) ?
                              int'(bws_pkg::DIM_RESET) : DIM_EFF;

   logic [bws_pkg::WEIGHT_W-1:0] weight_first_ff, weight_second_ff;
   logic [bws_pkg::DIM_W-1:0]    width_ff, height_ff;
   logic                         ac_mode_ff;
   logic [CNT_W-1:0]             total_ff, total_in;
   logic [bws_pkg::DIM_W-1:0]    width_clamp, height_clamp;
   logic [2*bws_pkg::DIM_W-1:0]  area;

   // Register writes; an index past the map is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_first_ff  <= bws_pkg::WEIGHT_RESET;
         weight_second_ff <= bws_pkg::WEIGHT_RESET;
         width_ff         <= bws_pkg::DIM_RESET;
         height_ff        <= bws_pkg::DIM_RESET;
         ac_mode_ff       <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            bws_pkg::CSR_WEIGHT_FIRST:  weight_first_ff  <= csr_wr_data;
            bws_pkg::CSR_WEIGHT_SECOND: weight_second_ff <= csr_wr_data;
            bws_pkg::CSR_WIDTH:         width_ff         <= csr_wr_data[bws_pkg::DIM_W-1:0];
            bws_pkg::CSR_HEIGHT:        height_ff        <= csr_wr_data[bws_pkg::DIM_W-1:0];
            bws_pkg::CSR_AC_MODE:       ac_mode_ff       <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // Clamp each dimension to 1..max and form the pixel total of a block.
   always_comb begin
      if (width_ff == '0) begin
         width_clamp = bws_pkg::DIM_W'(1);
      end else if (width_ff > bws_pkg::DIM_W'(DIM_EFF)) begin
         width_clamp = bws_pkg::DIM_W'(DIM_EFF);
      end else begin
         width_clamp = width_ff;
      end
      if (height_ff == '0) begin
         height_clamp = bws_pkg::DIM_W'(1);
      end else if (height_ff > bws_pkg::DIM_W'(DIM_EFF)) begin
         height_clamp = bws_pkg::DIM_W'(DIM_EFF);
      end else begin
         height_clamp = height_ff;
      end
      area     = width_clamp * height_clamp;
      total_in = area[CNT_W-1:0];
   end

   // The total is registered behind the width and height registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CNT_W'(RESET_DIM * RESET_DIM);
      end else begin
         total_ff <= total_in;
      end
   end

   assign cfg.weight_first  = weight_first_ff;
   assign cfg.weight_second = weight_second_ff;
   assign cfg.ac_mode       = ac_mode_ff;
   assign total             = total_ff;

endmodule

// File: sv/bws_ctrl.sv
module bws_ctrl #(
   parameter int MAG_W = 17,
   parameter int NUM_W = 35
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   ac_mode,
   input  bws_pkg::dp_status_type status,
   output bws_pkg::dp_cmd_type    cmd
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   typedef enum logic [3:0] {
      IDLE,
      PRED,
      SQUARE,
      ACCUM,
      MLOAD,
      MULT,
      DLOAD,
      DIV,
      FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Next state, step count and commands.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = PRED;
            end
         end
         PRED: begin
            cmd.pred_en = 1'b1;
            state_in    = SQUARE;
         end
         SQUARE: begin
            cmd.sq_en = 1'b1;
            state_in  = ACCUM;
         end
         ACCUM: begin
            cmd.acc_en = 1'b1;
            if (!status.last) begin
               state_in = IDLE;
            end else if (ac_mode) begin
               state_in = MLOAD;
            end else begin
               state_in = FINISH;
            end
         end
         MLOAD: begin
            cmd.mul_load = 1'b1;
            step_in      = STEP_W'(MAG_W);
            state_in     = MULT;
         end
         MULT: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = DLOAD;
            end
         end
         DLOAD: begin
            cmd.div_load = 1'b1;
            step_in      = STEP_W'(NUM_W);
            state_in     = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            // Load the result register once it is free or being emptied.
            cmd.use_dc = ac_mode;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/bws_dp.sv
module bws_dp #(
   parameter int PIXEL_BITS = 8,
   parameter int CNT_W      = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bws_pkg::dp_cmd_type           cmd,
   output bws_pkg::dp_status_type        status,
   input  bws_pkg::cfg_type              cfg,
   input  logic [CNT_W-1:0]              total,
   input  logic [PIXEL_BITS-1:0]         cur_pixel,
   input  logic [PIXEL_BITS-1:0]         ref1_pixel,
   input  logic [PIXEL_BITS-1:0]         ref2_pixel,
   output logic [bws_pkg::OUT_W-1:0]     error_energy
);

   localparam int PB      = PIXEL_BITS;
   localparam int PROD_W  = PB + bws_pkg::WEIGHT_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int RAW_W   = SUM_W - bws_pkg::Q_SHIFT;
   localparam int PIX_MAX = (2 ** PB) - 1;
   localparam int ERR_W   = PB + 1;
   localparam int SQ_W    = 2 * PB;
   localparam int ACC_W   = SQ_W + CNT_W;
   localparam int DIFF_W  = PB + CNT_W + 1;
   localparam int MAG_W   = PB + CNT_W;
   localparam int NUM_W   = 2 * MAG_W + 1;
   localparam int CMP_W   = (NUM_W > bws_pkg::OUT_W) ? NUM_W : bws_pkg::OUT_W + 1;

   logic [PB-1:0]              cur_ff;
   logic [PROD_W-1:0]          p1_ff, p2_ff;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic [SQ_W-1:0]            sq_ff;
   logic [ACC_W-1:0]           sq_acc_ff;
   logic signed [DIFF_W-1:0]   diff_acc_ff;
   logic [CNT_W-1:0]           count_ff, count_inc;
   logic [MAG_W-1:0]           mcand_ff, mplier_ff;
   logic [2*MAG_W-1:0]         prod_ff, addend;
   logic [NUM_W-1:0]           num_ff, num_load;
   logic [CNT_W-1:0]           rem_ff, rem_in, half_total;
   logic [bws_pkg::OUT_W-1:0]  energy_ff, energy_in;

   logic [SUM_W-1:0]           pred_sum;
   logic [RAW_W-1:0]           pred_raw;
   logic [PB-1:0]              pred;
   logic signed [2*ERR_W-1:0]  sq_full;
   logic [DIFF_W-1:0]          diff_bits, mag_full;
   logic [CNT_W:0]             trial, trial_sub;
   logic                       trial_ge;
   logic [CMP_W-1:0]           sq_ext, dc_ext, net;

   // Rounded Q15 prediction, saturated at the largest pixel value.
   always_comb begin
      pred_sum = SUM_W'(p1_ff) + SUM_W'(p2_ff) + SUM_W'(bws_pkg::ROUND_HALF);
      pred_raw = pred_sum[SUM_W-1:bws_pkg::Q_SHIFT];
      if (pred_raw > RAW_W'(PIX_MAX)) begin
         pred = PB'(PIX_MAX);
      end else begin
         pred = pred_raw[PB-1:0];
      end
      err_in = $signed({1'b0, cur_ff}) - $signed({1'b0, pred});
   end

   assign sq_full   = err_ff * err_ff;
   assign count_inc = count_ff + CNT_W'(1);
   assign status.last = (count_inc >= total);

   // Magnitude of the error sum for the DC term.
   always_comb begin
      diff_bits = diff_acc_ff;
      if (diff_bits[DIFF_W-1]) begin
         mag_full = ~diff_bits + 1'b1;
      end else begin
         mag_full = diff_bits;
      end
   end

   // Shift-add multiplier step, most significant multiplier bit first.
   assign addend = mplier_ff[MAG_W-1] ? (2*MAG_W)'(mcand_ff) : '0;

   // Restoring divider step by the pixel total.
   always_comb begin
      half_total = total >> 1;
      num_load   = NUM_W'(prod_ff) + NUM_W'(half_total);
      trial      = {rem_ff, num_ff[NUM_W-1]};
      trial_ge   = (trial >= {1'b0, total});
      trial_sub  = trial - {1'b0, total};
      rem_in     = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
   end

   // Block result: SSE less the optional DC term, clipped to the field.
   always_comb begin
      sq_ext = CMP_W'(sq_acc_ff);
      dc_ext = cmd.use_dc ? CMP_W'(num_ff) : '0;
      net    = (sq_ext >= dc_ext) ? (sq_ext - dc_ext) : '0;
      if (net > CMP_W'(bws_pkg::OUT_MAX)) begin
         energy_in = bws_pkg::OUT_MAX;
      end else begin
         energy_in = net[bws_pkg::OUT_W-1:0];
      end
   end

   // Per-item pipeline registers, serial unit registers and the result register.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_ff <= cur_pixel;
         p1_ff  <= ref1_pixel * cfg.weight_first;
         p2_ff  <= ref2_pixel * cfg.weight_second;
      end
      if (cmd.pred_en) begin
         err_ff <= err_in;
      end
      if (cmd.sq_en) begin
         sq_ff <= sq_full[SQ_W-1:0];
      end
      if (cmd.mul_load) begin
         mcand_ff  <= mag_full[MAG_W-1:0];
         mplier_ff <= mag_full[MAG_W-1:0];
         prod_ff   <= '0;
      end else if (cmd.mul_step) begin
         mplier_ff <= mplier_ff << 1;
         prod_ff   <= (prod_ff << 1) + addend;
      end
      if (cmd.div_load) begin
         num_ff <= num_load;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], trial_ge};
         rem_ff <= rem_in;
      end
      if (cmd.finish) begin
         energy_ff <= energy_in;
      end
   end

   // Block accumulators, cleared once the result is taken into the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_acc_ff   <= '0;
         diff_acc_ff <= '0;
         count_ff    <= '0;
      end else if (cmd.finish) begin
         sq_acc_ff   <= '0;
         diff_acc_ff <= '0;
         count_ff    <= '0;
      end else if (cmd.acc_en) begin
         sq_acc_ff   <= sq_acc_ff + ACC_W'(sq_ff);
         diff_acc_ff <= diff_acc_ff + DIFF_W'(err_ff);
         count_ff    <= count_inc;
      end
   end

   assign error_energy = energy_ff;

endmodule

// File: sv/bidir_weighted_sse.sv
// Channel   Direction  Payload                                  Handshake
// req_if    in         cur_pixel, ref1_pixel, ref2_pixel        valid / ready
// rsp_if    out        error_energy (26 bit)                    valid / ready
// csr_*     in         csr_index, csr_wr_data                   csr_wr_en, no wait
//
// An item passes through accept, prediction, square and accumulate; ready is high only
// while the item sequencer is free. The last item of a block then goes to the finish
// step in plain mode; in AC mode it first runs the bit-serial squaring of the error sum
// and the restoring division by the total. Reset is synchronous: registers take their
// reset values, the accumulators clear. The result register holds a waiting result while
// items of the next block go on; only the next block end waits for it to be taken.
module bidir_weighted_sse #(
   parameter int MAX_BLOCK_DIM = 16,
   parameter int PIXEL_BITS    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   bws_req_if.sink                         req_if,
   bws_rsp_if.source                       rsp_if,
   input  logic                            csr_wr_en,
   input  logic [bws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bws_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int DIM_EFF   = (MAX_BLOCK_DIM < bws_pkg::DIM_FIELD_MAX) ?
                              MAX_BLOCK_DIM : bws_pkg::DIM_FIELD_MAX;
   localparam int MAX_TOTAL = DIM_EFF * DIM_EFF;
   localparam int CNT_W     = $clog2(MAX_TOTAL + 1);
   localparam int MAG_W     = PIXEL_BITS + CNT_W;
   localparam int NUM_W     = 2 * MAG_W + 1;

   bws_pkg::cfg_type       cfg;
   bws_pkg::dp_cmd_type    cmd;
   bws_pkg::dp_status_type status;
   logic [CNT_W-1:0]       total;

   // Configuration registers and block total.
   bws_csr #(
      .MAX_BLOCK_DIM (MAX_BLOCK_DIM),
      .CNT_W         (CNT_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg),
      .total       (total)
   );

   // Item and block-end sequencer.
   bws_ctrl #(
      .MAG_W (MAG_W),
      .NUM_W (NUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .ac_mode   (cfg.ac_mode),
      .status    (status),
      .cmd       (cmd)
   );

   // Prediction, accumulation and DC-term arithmetic.
   bws_dp #(
      .PIXEL_BITS (PIXEL_BITS),
      .CNT_W      (CNT_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg),
      .total        (total),
      .cur_pixel    (req_if.cur_pixel),
      .ref1_pixel   (req_if.ref1_pixel),
      .ref2_pixel   (req_if.ref2_pixel),
      .error_energy (rsp_if.error_energy)
   );

endmodule

// File: sv/bws_checker.sv
module bws_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bws_pkg::OUT_W-1:0]   rsp_energy
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_energy))
      else $error("result changed or dropped while stalled");

   // One item at a time: no item is taken in the cycle after an accept.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("item accepted while the previous one is in flight");

   // No result rises while an accepted item is still in its prediction, square or accumulate state.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_fire, 1) && !$past(req_fire, 2) &&
                           !$past(req_fire, 3))
      else $error("result too soon after an accepted item");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind bidir_weighted_sse bws_checker u_bws_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_energy (rsp_if.error_energy)
);
